/* rtl/brf_pkg.sv */
// Shared types, constants and helper functions for the bracketed root finder.
package brf_pkg;

    localparam int WordBits   = 32;
    localparam int BudgetBits = 16;
    localparam int RegBits    = 31;
    localparam int CntBits    = BudgetBits + 1;
    localparam int ProdBits   = 2 * WordBits;
    localparam int StepBits   = $clog2(ProdBits + 1);

    // Register indexes on the configuration port.
    localparam logic [1:0] RegValTol   = 2'd0;
    localparam logic [1:0] RegStepTol  = 2'd1;
    localparam logic [1:0] RegBisWidth = 2'd2;
    localparam logic [1:0] RegBisValue = 2'd3;

    localparam logic KindRequest = 1'b0;
    localparam logic KindRoot    = 1'b1;
    localparam logic FuncStart   = 1'b0;

    // Result point selection from the controller.
    localparam logic [1:0] SelEndA = 2'd0;
    localparam logic [1:0] SelEndB = 2'd1;
    localparam logic [1:0] SelMid  = 2'd2;
    localparam logic [1:0] SelZero = 2'd3;

    // Sign classes returned by sgn.
    localparam logic [1:0] SgnZero = 2'd0;
    localparam logic [1:0] SgnPos  = 2'd1;
    localparam logic [1:0] SgnNeg  = 2'd2;

    // Search phase kept between items.
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT_A = 5'b00010,
        PH_WAIT_B = 5'b00100,
        PH_BISECT = 5'b01000,
        PH_SECANT = 5'b10000
    } t_phase;

    // Datapath operation selected by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_START, OP_LOAD_A, OP_LOAD_B, OP_BIS_UPD,
        OP_SEC_LOAD, OP_BIS_STEP, OP_SEC_PREP, OP_DIV_START, OP_SEC_END
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op op;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic val_a_ok;
        logic val_b_ok;
        logic val_in_ok;
        logic gap_ok;
        logic bis_stop;
        logic sign_diff;
        logic den_zero;
        logic budget_zero;
        logic budget_lt3;
        logic div_busy;
    } t_stat;

    localparam logic signed [WordBits-1:0] WMax = {1'b0, {(WordBits-1){1'b1}}};
    localparam logic signed [WordBits-1:0] WMin = {1'b1, {(WordBits-1){1'b0}}};

    // Saturating signed add.
    function automatic logic signed [WordBits-1:0] sat_add(
        input logic signed [WordBits-1:0] x, input logic signed [WordBits-1:0] y);
        logic signed [WordBits:0] s;
        s = {x[WordBits-1], x} + {y[WordBits-1], y};
        if (s[WordBits] != s[WordBits-1]) begin
            return s[WordBits] ? WMin : WMax;
        end
        return s[WordBits-1:0];
    endfunction

    // Saturating signed subtract.
    function automatic logic signed [WordBits-1:0] sat_sub(
        input logic signed [WordBits-1:0] x, input logic signed [WordBits-1:0] y);
        logic signed [WordBits:0] s;
        s = {x[WordBits-1], x} - {y[WordBits-1], y};
        if (s[WordBits] != s[WordBits-1]) begin
            return s[WordBits] ? WMin : WMax;
        end
        return s[WordBits-1:0];
    endfunction

    // Magnitude as an unsigned word.
    function automatic logic [WordBits-1:0] mag(input logic signed [WordBits-1:0] x);
        return x[WordBits-1] ? (~x + 1'b1) : x;
    endfunction

    // Sign class: zero, positive or negative.
    function automatic logic [1:0] sgn(input logic signed [WordBits-1:0] x);
        return x[WordBits-1] ? SgnNeg : ((x != '0) ? SgnPos : SgnZero);
    endfunction

endpackage

/* rtl/brf_div.sv */
// Restoring divider, one quotient bit per cycle, saturating quotient magnitude.
module brf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [brf_pkg::ProdBits-1:0]      i_num,
    input  logic [brf_pkg::WordBits-1:0]      i_den,
    output logic                              o_busy,
    output logic [brf_pkg::WordBits-1:0]      o_quot
);

    logic [brf_pkg::ProdBits-1:0] r_num, n_num;
    logic [brf_pkg::WordBits:0]   r_rem, n_rem;
    logic [brf_pkg::WordBits-1:0] r_den;
    logic [brf_pkg::ProdBits-1:0] r_q, n_q;
    logic [brf_pkg::StepBits-1:0] r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic [brf_pkg::WordBits:0]   w_sh;

    // One shift and subtract step.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_sh   = {r_rem[brf_pkg::WordBits-1:0], r_num[brf_pkg::ProdBits-1]};
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = brf_pkg::StepBits'(brf_pkg::ProdBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[brf_pkg::ProdBits-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[brf_pkg::ProdBits-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[brf_pkg::ProdBits-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != brf_pkg::StepBits'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    // Saturate to the largest positive word.
    assign o_quot = (r_q[brf_pkg::ProdBits-1:brf_pkg::WordBits-1] != '0) ?
                    brf_pkg::WMax : r_q[brf_pkg::WordBits-1:0];

endmodule

/* rtl/brf_dp.sv */
// Datapath: interval ends, values, budget, secant product and divider.
module brf_dp (
    input  logic                              i_clk,
    input  brf_pkg::t_cmd                     i_cmd,
    input  logic signed [brf_pkg::WordBits-1:0] i_left,
    input  logic signed [brf_pkg::WordBits-1:0] i_right,
    input  logic [brf_pkg::BudgetBits-1:0]    i_budget,
    input  logic signed [brf_pkg::WordBits-1:0] i_fvalue,
    input  logic [brf_pkg::RegBits-1:0]       i_val_tol,
    input  logic [brf_pkg::RegBits-1:0]       i_step_tol,
    input  logic [brf_pkg::RegBits-1:0]       i_bis_width,
    input  logic [brf_pkg::RegBits-1:0]       i_bis_value,
    input  logic                              i_rst_n,
    output brf_pkg::t_stat                    o_stat,
    output logic signed [brf_pkg::WordBits-1:0] o_end_a,
    output logic signed [brf_pkg::WordBits-1:0] o_end_b,
    output logic signed [brf_pkg::WordBits-1:0] o_mid
);

    logic signed [brf_pkg::WordBits-1:0] r_end_a, r_end_b, r_val_a, r_val_b, r_half, r_mid;
    logic [brf_pkg::CntBits-1:0]         r_budget;
    logic [brf_pkg::ProdBits-1:0]        r_prod;
    logic [brf_pkg::WordBits-1:0]        r_den;
    logic                                r_neg;
    logic signed [brf_pkg::WordBits-1:0] w_gap, w_den, w_half;
    logic [1:0]                          w_sa, w_sd, w_sn;
    logic                                w_div_busy;
    logic [brf_pkg::WordBits-1:0]        w_quot;

    assign w_gap  = brf_pkg::sat_sub(r_end_b, r_end_a);
    assign w_den  = brf_pkg::sat_sub(r_val_b, r_val_a);
    assign w_half = r_half / 2;
    assign w_sa   = brf_pkg::sgn(r_val_a);
    assign w_sd   = brf_pkg::sgn(w_gap);
    assign w_sn   = brf_pkg::sgn(w_den);

    brf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == brf_pkg::OP_DIV_START),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // State update per controller command.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            brf_pkg::OP_START: begin
                r_end_a  <= i_left;
                r_end_b  <= i_right;
                r_budget <= {1'b0, i_budget};
            end
            brf_pkg::OP_LOAD_A: r_val_a <= i_fvalue;
            brf_pkg::OP_LOAD_B: begin
                r_val_b  <= i_fvalue;
                r_budget <= r_budget - brf_pkg::CntBits'(2);
                r_half   <= w_gap;
            end
            brf_pkg::OP_BIS_UPD: begin
                if (brf_pkg::sgn(i_fvalue) != w_sa) begin
                    r_end_b <= r_mid;
                    r_val_b <= i_fvalue;
                end else begin
                    r_end_a <= r_mid;
                    r_val_a <= i_fvalue;
                end
            end
            brf_pkg::OP_SEC_LOAD: r_val_a <= i_fvalue;
            brf_pkg::OP_BIS_STEP: begin
                r_budget <= r_budget - 1'b1;
                r_half   <= w_half;
                r_mid    <= brf_pkg::sat_add(r_end_a, w_half);
            end
            brf_pkg::OP_SEC_PREP: begin
                r_budget <= r_budget - 1'b1;
                r_prod   <= brf_pkg::mag(r_val_a) * brf_pkg::mag(w_gap);
                r_den    <= brf_pkg::mag(w_den);
                // The step is added when none of the three signs is zero and an odd number of them is negative.
                r_neg    <= ((w_sa == brf_pkg::SgnNeg) ^ (w_sd == brf_pkg::SgnNeg) ^
                             (w_sn == brf_pkg::SgnNeg)) &&
                            w_sa != brf_pkg::SgnZero && w_sd != brf_pkg::SgnZero &&
                            w_sn != brf_pkg::SgnZero;
            end
            brf_pkg::OP_SEC_END: begin
                r_end_b <= r_end_a;
                r_val_b <= r_val_a;
                r_end_a <= r_neg ? brf_pkg::sat_add(r_end_a, w_quot)
                                 : brf_pkg::sat_sub(r_end_a, w_quot);
            end
            default: ;
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_stat.val_a_ok    = brf_pkg::mag(r_val_a) <= {1'b0, i_val_tol};
        o_stat.val_b_ok    = brf_pkg::mag(r_val_b) <= {1'b0, i_val_tol};
        o_stat.val_in_ok   = brf_pkg::mag(i_fvalue) <= {1'b0, i_val_tol};
        o_stat.gap_ok      = brf_pkg::mag(w_gap) <= {1'b0, i_step_tol};
        o_stat.bis_stop    = brf_pkg::mag(r_half) < {1'b0, i_bis_width} ||
                             brf_pkg::mag(i_fvalue) < {1'b0, i_bis_value};
        o_stat.sign_diff   = w_sa != brf_pkg::sgn(r_val_b);
        o_stat.den_zero    = r_val_a == r_val_b;
        o_stat.budget_zero = r_budget == '0;
        o_stat.budget_lt3  = r_budget < brf_pkg::CntBits'(3);
        o_stat.div_busy    = w_div_busy;
    end

    assign o_end_a = r_end_a;
    assign o_end_b = r_end_b;
    assign o_mid   = r_mid;

endmodule

/* rtl/brf_ctrl.sv */
// Controller: handshake, search phase and step sequencing.
module brf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_func,
    input  logic                 i_out_ready,
    input  brf_pkg::t_stat       i_stat,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output brf_pkg::t_cmd        o_cmd,
    output logic [1:0]           o_sel,
    output logic                 o_kind,
    output logic                 o_fault
);

    // Work steps inside one item.
    typedef enum logic [5:0] {
        ST_WAIT  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_AFTER = 6'b000100,
        ST_SEC   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_st;

    t_st            r_st, n_st;
    brf_pkg::t_phase r_ph, n_ph;
    logic           r_func;
    logic           r_ov, n_ov;
    logic [1:0]     r_sel, n_sel;
    logic           r_kind, n_kind, r_fault, n_fault;
    logic [1:0]     r_csel, n_csel;
    logic           w_acc;

    assign o_in_ready = (r_st == ST_WAIT) && !r_ov;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_ov = r_ov; n_sel = r_sel;
        n_kind = r_kind; n_fault = r_fault; n_csel = r_csel;
        o_cmd.op = brf_pkg::OP_NONE;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_st)
            ST_WAIT: begin
                if (w_acc) begin
                    n_st = ST_EVAL;
                    if (i_func == brf_pkg::FuncStart) begin
                        o_cmd.op = brf_pkg::OP_START;
                    end
                end
            end
            ST_EVAL: begin
                n_st = ST_DONE;
                if (r_func == brf_pkg::FuncStart) begin
                    if (i_stat.budget_zero) begin
                        n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                        n_sel = brf_pkg::SelEndA;
                    end else begin
                        n_ph = brf_pkg::PH_WAIT_A; n_kind = brf_pkg::KindRequest;
                        n_sel = brf_pkg::SelEndA;
                    end
                    n_fault = 1'b0;
                end else begin
                    n_fault = 1'b0;
                    unique case (r_ph)
                        brf_pkg::PH_WAIT_A: begin
                            o_cmd.op = brf_pkg::OP_LOAD_A;
                            if (i_stat.budget_lt3) begin
                                n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                                n_sel = i_stat.val_in_ok ? brf_pkg::SelEndA
                                                         : brf_pkg::SelEndB;
                            end else begin
                                n_ph = brf_pkg::PH_WAIT_B; n_kind = brf_pkg::KindRequest;
                                n_sel = brf_pkg::SelEndB;
                            end
                        end
                        brf_pkg::PH_WAIT_B: begin
                            o_cmd.op = brf_pkg::OP_LOAD_B;
                            n_st = ST_AFTER; n_csel = brf_pkg::SelEndA;
                        end
                        brf_pkg::PH_BISECT: begin
                            o_cmd.op = brf_pkg::OP_BIS_UPD;
                            if (i_stat.bis_stop) begin
                                n_st = ST_AFTER; n_csel = brf_pkg::SelMid;
                            end else if (!i_stat.budget_zero) begin
                                n_st = ST_AFTER; n_csel = brf_pkg::SelZero;
                            end else begin
                                n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                                n_sel = brf_pkg::SelMid;
                            end
                        end
                        brf_pkg::PH_SECANT: begin
                            o_cmd.op = brf_pkg::OP_SEC_LOAD;
                            n_st = ST_SEC;
                        end
                        default: begin
                            n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                            n_sel = brf_pkg::SelZero;
                        end
                    endcase
                end
            end
            ST_AFTER: begin
                // SelZero in r_csel marks a plain bisection step.
                if (r_ph == brf_pkg::PH_WAIT_B && i_stat.sign_diff ||
                    r_csel == brf_pkg::SelZero) begin
                    o_cmd.op = brf_pkg::OP_BIS_STEP;
                    n_ph = brf_pkg::PH_BISECT; n_kind = brf_pkg::KindRequest;
                    n_sel = brf_pkg::SelMid;
                    n_st = ST_DONE;
                end else if (i_stat.budget_zero) begin
                    n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot; n_sel = r_csel;
                    n_st = ST_DONE;
                end else if (i_stat.val_b_ok || i_stat.gap_ok) begin
                    n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                    n_sel = brf_pkg::SelEndB;
                    n_st = ST_DONE;
                end else if (i_stat.val_a_ok) begin
                    n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                    n_sel = brf_pkg::SelEndA;
                    n_st = ST_DONE;
                end else begin
                    n_st = ST_SEC; n_csel = brf_pkg::SelEndB;
                end
            end
            ST_SEC: begin
                // Entry from the secant phase re-checks tolerances and the budget first.
                if (r_ph == brf_pkg::PH_SECANT && r_csel != brf_pkg::SelEndB &&
                    (i_stat.val_a_ok || i_stat.gap_ok || i_stat.budget_zero)) begin
                    n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                    n_sel = brf_pkg::SelEndA;
                    n_st = ST_DONE;
                end else if (i_stat.den_zero) begin
                    o_cmd.op = brf_pkg::OP_SEC_PREP;
                    n_ph = brf_pkg::PH_IDLE; n_kind = brf_pkg::KindRoot;
                    n_sel = brf_pkg::SelEndA;
                    n_fault = 1'b1; n_st = ST_DONE;
                end else begin
                    o_cmd.op = brf_pkg::OP_SEC_PREP;
                    n_st = ST_DIV; n_csel = brf_pkg::SelZero;
                end
            end
            ST_DIV: begin
                if (r_csel == brf_pkg::SelZero) begin
                    o_cmd.op = brf_pkg::OP_DIV_START; n_csel = brf_pkg::SelMid;
                end else if (!i_stat.div_busy) begin
                    o_cmd.op = brf_pkg::OP_SEC_END;
                    n_ph = brf_pkg::PH_SECANT; n_kind = brf_pkg::KindRequest;
                    n_sel = brf_pkg::SelEndA;
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1; n_st = ST_WAIT;
                end
            end
            default: n_st = ST_WAIT;
        endcase
        if (r_st == ST_EVAL) begin
            n_csel = (r_func != brf_pkg::FuncStart && r_ph == brf_pkg::PH_SECANT) ?
                     brf_pkg::SelEndA : n_csel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_WAIT; r_ph <= brf_pkg::PH_IDLE; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_ov <= n_ov;
        end
        if (w_acc) r_func <= i_func;
        r_csel <= n_csel;
        if (r_st == ST_DONE && (!r_ov || i_out_ready)) begin
            r_sel <= n_sel; r_kind <= n_kind; r_fault <= n_fault;
        end else if (r_st != ST_DONE) begin
            r_sel <= n_sel; r_kind <= n_kind; r_fault <= n_fault;
        end
    end

    assign o_out_valid = r_ov;
    assign o_sel       = r_sel;
    assign o_kind      = r_kind;
    assign o_fault     = r_fault;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_st == ST_EVAL) else $error("accept did not start work");
    a_fault_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_fault |-> r_kind) else $error("fault without root");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_WAIT |-> !o_in_ready) else $error("ready while busy");
`endif

endmodule

/* rtl/bracketed_root_finder.sv */
// Top level of the bracketed root finder.
// A valid result follows the input transfer through ST_EVAL and ST_DONE; a bisection
// step or the post-bisection checks pass through ST_AFTER as well, and a secant step
// waits in ST_DIV for the one-bit-per-cycle divider over the 64-bit product.
// One item at a time; the next is taken once the result transfer has happened.
// Reset (synchronous, active low) clears the phase, handshake state and the
// configuration registers to their defaults.
module bracketed_root_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [111:0] s_axis_tdata, // left_end, right_end, eval_budget, fvalue
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // point, div_fault, zero fill
    output logic        m_axis_tuser,  // kind
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    logic [brf_pkg::RegBits-1:0] r_val_tol, r_step_tol, r_bis_w, r_bis_v;
    brf_pkg::t_cmd w_cmd;
    brf_pkg::t_stat w_stat;
    logic [1:0] w_sel;
    logic w_kind, w_fault;
    logic signed [31:0] w_a, w_b, w_m, w_point;
    logic signed [31:0] r_f;
    logic signed [31:0] r_point;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_tol <= 31'd66; r_step_tol <= 31'd66;
            r_bis_w <= 31'd6554; r_bis_v <= 31'd3277;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                brf_pkg::RegValTol:   r_val_tol  <= i_cfg_data;
                brf_pkg::RegStepTol:  r_step_tol <= i_cfg_data;
                brf_pkg::RegBisWidth: r_bis_w    <= i_cfg_data;
                brf_pkg::RegBisValue: r_bis_v    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    brf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_func(s_axis_tuser), .i_out_ready(m_axis_tready), .i_stat(w_stat),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd),
        .o_sel(w_sel), .o_kind(w_kind), .o_fault(w_fault)
    );

    // The start fields load the datapath at the transfer itself; the function
    // value is used in the following cycles, so it is latched with the transfer.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_f <= s_axis_tdata[111:80];
        end
    end

    brf_dp u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_left(s_axis_tdata[31:0]),
        .i_right(s_axis_tdata[63:32]), .i_budget(s_axis_tdata[79:64]),
        .i_fvalue(r_f), .i_val_tol(r_val_tol),
        .i_step_tol(r_step_tol), .i_bis_width(r_bis_w), .i_bis_value(r_bis_v),
        .i_rst_n(i_rst_n), .o_stat(w_stat), .o_end_a(w_a), .o_end_b(w_b), .o_mid(w_m)
    );

    // Result point; it is held while a valid result waits for the output transfer.
    always_comb begin
        unique case (w_sel)
            brf_pkg::SelEndA: w_point = w_a;
            brf_pkg::SelEndB: w_point = w_b;
            brf_pkg::SelMid:  w_point = w_m;
            default:          w_point = '0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!m_axis_tvalid || m_axis_tready) r_point <= w_point;
    end

    assign m_axis_tdata = {7'd0, w_fault, r_point};
    assign m_axis_tuser = w_kind;

endmodule

/* tb/tb.sv */
// Testbench for the bracketed root finder: directed and random start and value transfers.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0] t_word;

    // Expected result of one transfer.
    typedef struct packed {
        logic  kind;
        t_word point;
        logic  fault;
    } t_answer;

    // Search state held by the predictor.
    typedef enum logic [2:0] {
        S_IDLE, S_WAIT_A, S_WAIT_B, S_BISECT, S_SECANT
    } t_search;

    // Scoreboard: predicts each answer on an accepted input and checks results in order.
    class root_scoreboard;
        logic [30:0] tol[4];
        t_search     search;
        t_word       end_a, end_b, val_a, val_b, half_w, mid;
        logic [15:0] budget;
        t_answer     answers[$];
        int          errors;

        function void clear();
            tol[0] = 66; tol[1] = 66; tol[2] = 6554; tol[3] = 3277;
            search = S_IDLE;
            end_a = 0; end_b = 0; val_a = 0; val_b = 0; half_w = 0; mid = 0;
            budget = 0;
            answers.delete();
            errors = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function t_answer give(logic kind, t_word p, logic fault);
            t_answer r;
            r.kind = kind; r.point = p; r.fault = fault;
            if (kind == brf_pkg::KindRoot) search = S_IDLE;
            return r;
        endfunction

        function int sign3(t_word x);
            return (x < 0) ? -1 : ((x > 0) ? 1 : 0);
        endfunction

        // Absolute value of |x*y/d|, saturated to the largest positive word.
        function logic [31:0] scaled_term(logic [31:0] x, logic [31:0] y, logic [31:0] d);
            logic [63:0] q;
            q = (64'(x) * 64'(y)) / 64'(d);
            return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        endfunction

        function t_answer secant();
            t_word d, den;
            logic [31:0] q;
            int s;
            budget = budget - 1;
            if (val_b == val_a) return give(brf_pkg::KindRoot, end_a, 1'b1);
            d   = brf_pkg::sat_sub(end_b, end_a);
            den = brf_pkg::sat_sub(val_b, val_a);
            q   = scaled_term(brf_pkg::mag(val_a), brf_pkg::mag(d), brf_pkg::mag(den));
            s   = sign3(val_a) * sign3(d) * sign3(den);
            end_b = end_a;
            val_b = val_a;
            end_a = (s < 0) ? brf_pkg::sat_add(end_a, t_word'(q))
                            : brf_pkg::sat_sub(end_a, t_word'(q));
            search = S_SECANT;
            return give(brf_pkg::KindRequest, end_a, 1'b0);
        endfunction

        function t_answer after_halving(t_word c);
            if (budget == 0) return give(brf_pkg::KindRoot, c, 1'b0);
            if (brf_pkg::mag(val_b) <= tol[0] ||
                brf_pkg::mag(brf_pkg::sat_sub(end_b, end_a)) <= tol[1])
                return give(brf_pkg::KindRoot, end_b, 1'b0);
            if (brf_pkg::mag(val_a) <= tol[0]) return give(brf_pkg::KindRoot, end_a, 1'b0);
            return secant();
        endfunction

        function t_answer halve();
            budget = budget - 1;
            half_w = half_w / 2;
            mid    = brf_pkg::sat_add(end_a, half_w);
            search = S_BISECT;
            return give(brf_pkg::KindRequest, mid, 1'b0);
        endfunction

        function t_answer predict(logic func, t_word l, t_word r, logic [15:0] b, t_word fv);
            if (func == brf_pkg::FuncStart) begin
                end_a = l; end_b = r; budget = b;
                if (b == 0) return give(brf_pkg::KindRoot, l, 1'b0);
                search = S_WAIT_A;
                return give(brf_pkg::KindRequest, l, 1'b0);
            end
            case (search)
                S_WAIT_A: begin
                    val_a = fv;
                    if (budget < 3)
                        return give(brf_pkg::KindRoot,
                                    (brf_pkg::mag(fv) <= tol[0]) ? end_a : end_b, 1'b0);
                    search = S_WAIT_B;
                    return give(brf_pkg::KindRequest, end_b, 1'b0);
                end
                S_WAIT_B: begin
                    val_b = fv;
                    budget = budget - 2;
                    if (sign3(val_a) != sign3(val_b)) begin
                        half_w = brf_pkg::sat_sub(end_b, end_a);
                        return halve();
                    end
                    return after_halving(end_a);
                end
                S_BISECT: begin
                    if (sign3(fv) != sign3(val_a)) begin
                        end_b = mid; val_b = fv;
                    end else begin
                        end_a = mid; val_a = fv;
                    end
                    if (brf_pkg::mag(half_w) < tol[2] || brf_pkg::mag(fv) < tol[3])
                        return after_halving(mid);
                    if (budget > 0) return halve();
                    return give(brf_pkg::KindRoot, mid, 1'b0);
                end
                S_SECANT: begin
                    val_a = fv;
                    if (brf_pkg::mag(val_a) <= tol[0] ||
                        brf_pkg::mag(brf_pkg::sat_sub(end_b, end_a)) <= tol[1])
                        return give(brf_pkg::KindRoot, end_a, 1'b0);
                    if (budget > 0) return secant();
                    return give(brf_pkg::KindRoot, end_a, 1'b0);
                end
                default: return give(brf_pkg::KindRoot, 0, 1'b0);
            endcase
        endfunction

        function void note_input(logic func, t_word l, t_word r, logic [15:0] b, t_word fv);
            answers.push_back(predict(func, l, r, b, fv));
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            if (answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            want = answers.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0b, want %0b", got.kind, want.kind));
            if (got.point !== want.point)
                report_mismatch($sformatf("point %h, want %h", got.point, want.point));
            if (got.fault !== want.fault)
                report_mismatch($sformatf("fault %0b, want %0b", got.fault, want.fault));
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [30:0]  i_cfg_data;

    root_scoreboard roots;
    bit  no_idle;
    int  quiet_cycles = 0;
    t_word last_point;
    logic  last_kind;

    bracketed_root_finder u_top (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random stalls, checking every transfer.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser;
            got.point = m_axis_tdata[31:0];
            got.fault = m_axis_tdata[32];
            last_kind  = got.kind;
            last_point = got.point;
            roots.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One input transfer, with an optional idle burst first.
    task automatic send(logic func, t_word l, t_word r, logic [15:0] b, t_word fv);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {fv, b, r, l};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        roots.note_input(func, l, r, b, fv);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (roots.answers.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] v);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        roots.tol[idx] = v;
    endtask

    function t_word rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 20))) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Value returned by an external function f(x) = x - root, with noise now and then.
    function t_word eval_at(t_word x, t_word root);
        if ($urandom_range(0, 9) == 0) return rand_word();
        return brf_pkg::sat_sub(x, root);
    endfunction

    // A whole search: start, then answer requests until a root or an early stop.
    task automatic search_run(int max_items, ref int count);
        t_word l, r, root;
        logic [15:0] b;
        l = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
        r = l + $signed(32'($urandom_range(1, 32'h00FF_FFFF)));
        root = l + (r - l) / 3;
        b = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3))
                                        : 16'($urandom_range(3, 40));
        send(brf_pkg::FuncStart, l, r, b, $urandom);
        count++;
        while (roots.answers.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        while (last_kind == brf_pkg::KindRequest && count < max_items) begin
            if ($urandom_range(0, 40) == 0) break;
            send(1'b1, $urandom, $urandom, 16'($urandom), eval_at(last_point, root));
            count++;
            while (roots.answers.size() != 0) @(negedge i_clk);
            @(negedge i_clk);
        end
    endtask

    initial begin
        int count;
        roots = new();
        roots.clear();
        no_idle = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
        i_cfg_we = 1'b0; i_cfg_index = brf_pkg::RegValTol; i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: value with no search, zero budget, short budgets, extremes.
        send(1'b1, 0, 0, 0, 32'sh7FFF_FFFF);
        send(brf_pkg::FuncStart, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
        send(brf_pkg::FuncStart, 32'sh0001_0000, 32'sh0002_0000, 1, 0);
        send(1'b1, 0, 0, 0, 0);
        send(brf_pkg::FuncStart, 32'sh0001_0000, 32'sh0002_0000, 2, 0);
        send(1'b1, 0, 0, 0, 32'sh0001_0000);
        send(brf_pkg::FuncStart, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 0);
        send(1'b1, 0, 0, 0, 32'sh8000_0000);
        send(1'b1, 0, 0, 0, 32'sh7FFF_FFFF);
        send(1'b1, 0, 0, 0, 32'sh0000_1000);
        // Same-sign ends with equal values give a zero secant denominator.
        send(brf_pkg::FuncStart, 32'sh0001_0000, 32'sh0003_0000, 10, 0);
        send(1'b1, 0, 0, 0, 32'sh0005_0000);
        send(1'b1, 0, 0, 0, 32'sh0005_0000);
        // Start dropping a running search.
        send(brf_pkg::FuncStart, 0, 32'sh0004_0000, 8, 0);
        send(brf_pkg::FuncStart, 32'shFFFF_0000, 32'sh0001_0000, 5, 0);
        send(1'b1, 0, 0, 0, 32'shFFFF_0000);
        send(1'b1, 0, 0, 0, 32'sh0001_0000);
        drain();

        // Random phases, each with its own register setting.
        count = 0;
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 4; k++) begin
                case (ph)
                    0: write_reg(k[1:0], 31'h7FFF_FFFF);
                    1: write_reg(k[1:0], 31'd0);
                    2: write_reg(k[1:0], 31'($urandom_range(0, 20000)));
                    3: write_reg(k[1:0], 31'($urandom));
                    default: write_reg(k[1:0], (k < 2) ? 31'd66 : 31'd300);
                endcase
            end
            if (ph == 4) no_idle = 1'b1;
            while (count < 380 * (ph + 1)) begin
                if ($urandom_range(0, 5) == 0) begin
                    send(1'($urandom_range(0, 1)), rand_word(), rand_word(),
                         16'($urandom_range(0, 6)), rand_word());
                    count++;
                end else begin
                    search_run(380 * (ph + 1), count);
                end
            end
            drain();
        end

        if (roots.answers.size() == 0 && roots.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
